[design/mffca_pkg.sv]
// ----------------------------------------------------------------------------
// mffca_pkg: shared types and constants of the chunk allocator
// Widths, status codes and sequencer states.
// ----------------------------------------------------------------------------
package mffca_pkg;

  localparam int unsigned ChunksPerBlockDef = 128;
  localparam int unsigned NumBlockSlotsDef  = 16;
  localparam int unsigned HandleW           = 11;
  localparam int unsigned StatusW           = 2;
  localparam int unsigned WordW             = 64;

  localparam logic [StatusW-1:0] StOk      = 2'd0;
  localparam logic [StatusW-1:0] StNoSlot  = 2'd1;
  localparam logic [StatusW-1:0] StNotAllc = 2'd2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_OPEN,
    S_SCAN,
    S_SCANW,
    S_FREE_RD,
    S_FREE_CHK,
    S_REMOVE,
    S_SORT,
    S_DONE
  } state_e;

  // Status bus from the scan unit to the sequencer.
  typedef struct packed {
    logic                found;
    logic [WordW-1:0]    word;
  } scan_t;

endpackage

[design/mffca_bitmem.sv]
// ----------------------------------------------------------------------------
// mffca_bitmem: allocation bitmap memory
// One 64-bit word per row, one write port and one registered read port.
// ----------------------------------------------------------------------------
module mffca_bitmem #(
  parameter int unsigned Rows = 32,
  parameter int unsigned AddrW = 5
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [63:0]      rdata_o
);
  logic [63:0] mem [Rows];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

[design/most_filled_first_chunk_allocator_top.sv]
// ----------------------------------------------------------------------------
// most_filled_first_chunk_allocator_top: bitmap slab allocator
// Sequenced allocate/free of fixed-size chunks, most-filled block first.
// ----------------------------------------------------------------------------
// One item at a time: a small sequencer drives one shared compare/step path,
// and in_stall_o is high from the accepting edge until the sequencer is back
// in idle. An allocate walks the usage list one entry a cycle. If no block
// has room it opens a fresh one in the lowest free slot, skipping live slots
// in turn, then sweeps the new block's bitmap words clear, one a cycle; with
// no free slot it reports StNoSlot. Once it has a block it scans the bitmap
// one 64-bit word at a time through the registered memory port, reading in
// S_SCAN and testing in S_SCANW. A free reads the word in S_FREE_RD, checks
// and clears the bit in S_FREE_CHK, and removes an emptied block from the
// list one entry a cycle. Every successful allocate and accepted free ends
// with one insertion-sort pass. Only the touched block can be out of place,
// so the pass makes at most live_count - 1 swaps. The live count sets how
// long an item keeps the block busy. The result is held in an output
// register until taken, so a new beat can be accepted while it waits; the
// sequencer holds in its final state only while an older result is untaken.
// No clearing pass after reset: a block's bitmap is swept when it is opened.
module most_filled_first_chunk_allocator_top #(
  parameter int unsigned BLOCK_CHUNKS    = mffca_pkg::ChunksPerBlockDef,
  parameter int unsigned NUM_BLOCK_SLOTS = mffca_pkg::NumBlockSlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic [mffca_pkg::HandleW-1:0]  handle_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [mffca_pkg::HandleW-1:0]  chunk_handle_o,
  output logic [mffca_pkg::StatusW-1:0]  status_o,
  output logic                           block_released_o
);
  import mffca_pkg::*;

  localparam int unsigned WPB    = (BLOCK_CHUNKS + 63) / 64;
  localparam int unsigned WIW    = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int unsigned SW     = (NUM_BLOCK_SLOTS > 1) ? $clog2(NUM_BLOCK_SLOTS) : 1;
  localparam int unsigned CW     = $clog2(NUM_BLOCK_SLOTS + 1);
  localparam int unsigned FW     = $clog2(BLOCK_CHUNKS + 1);
  localparam int unsigned ROWS   = NUM_BLOCK_SLOTS * WPB;
  localparam int unsigned AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PW     = 32;
  localparam logic [FW-1:0] FULLC = FW'(BLOCK_CHUNKS);

  state_e state_q, state_d;

  logic [FW-1:0]  free_q [NUM_BLOCK_SLOTS];
  logic           live_q [NUM_BLOCK_SLOTS];
  logic [SW-1:0]  order_q [NUM_BLOCK_SLOTS];
  logic [CW-1:0]  cnt_q;

  logic [HandleW-1:0] hdl_q;
  logic [SW-1:0]  slot_q;
  logic [CW-1:0]  i_q;
  logic [CW-1:0]  j_q;
  logic [WIW-1:0] w_q;
  logic           rel_q;
  logic [HandleW-1:0] res_h_q;
  logic [StatusW-1:0] res_s_q;

  logic           ov_q;
  logic [HandleW-1:0] oh_q;
  logic [StatusW-1:0] os_q;
  logic           orl_q;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [63:0]    wdata, rdata;

  // Free handle decode: compare against each block's base handle, subtract it.
  // A handle past the last block decodes to slot NUM_BLOCK_SLOTS.
  logic [PW-1:0]  fslot_w, fidx_w;
  always_comb begin
    fslot_w = '0;
    for (int s = 1; s < NUM_BLOCK_SLOTS; s++) begin
      if (PW'(hdl_q) >= PW'(s) * PW'(BLOCK_CHUNKS)) fslot_w = PW'(s);
    end
    if (PW'(hdl_q) >= PW'(NUM_BLOCK_SLOTS) * PW'(BLOCK_CHUNKS)) begin
      fslot_w = PW'(NUM_BLOCK_SLOTS);
    end
    fidx_w = PW'(hdl_q) - fslot_w * PW'(BLOCK_CHUNKS);
  end

  logic [AW-1:0] row_base;
  assign row_base = AW'(PW'(slot_q) * PW'(WPB));

  mffca_bitmem #(.Rows(ROWS), .AddrW(AW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // Lowest clear bit of the read word, within the valid chunk range.
  scan_t      scan;
  logic [5:0] bitpos;
  logic [63:0] vmask;
  always_comb begin
    vmask = '1;
    for (int b = 0; b < 64; b++) begin
      if (PW'(w_q) * 64 + PW'(b) >= PW'(BLOCK_CHUNKS)) vmask[b] = 1'b0;
    end
    scan.word  = rdata;
    scan.found = 1'b0;
    bitpos     = '0;
    for (int b = 63; b >= 0; b--) begin
      if (vmask[b] && !rdata[b]) begin
        scan.found = 1'b1;
        bitpos     = 6'(b);
      end
    end
  end

  logic [5:0] fbit;
  assign fbit = 6'(fidx_w % 64);
  logic [WIW-1:0] fword;
  assign fword = WIW'(fidx_w / 64);

  // Sort compare: shared unit compares entry j-1 against entry j.
  logic sort_swap;
  logic [SW-1:0] oa, ob;
  always_comb begin
    oa = order_q[SW'(j_q - CW'(1))];
    ob = order_q[SW'(j_q)];
    sort_swap = (j_q != '0) && (free_q[oa] > free_q[ob]);
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i && !in_stall_o) begin
        state_d = (func_i == FuncFree) ? S_FREE_RD : S_FIND;
      end
      S_FIND: begin
        if (i_q >= cnt_q) state_d = S_OPEN;
        else if (free_q[order_q[SW'(i_q)]] != '0) state_d = S_SCAN;
      end
      S_OPEN: begin
        if (cnt_q >= CW'(NUM_BLOCK_SLOTS)) state_d = S_DONE;
        else if (live_q[SW'(i_q)] && i_q < CW'(NUM_BLOCK_SLOTS)) state_d = S_OPEN;
        else if (PW'(w_q) == PW'(WPB - 1)) state_d = S_SCAN;
      end
      S_SCAN:  state_d = S_SCANW;
      S_SCANW: state_d = scan.found ? S_SORT : S_SCAN;
      S_FREE_RD: begin
        if (fslot_w >= PW'(NUM_BLOCK_SLOTS) || !live_q[SW'(fslot_w)]) state_d = S_DONE;
        else state_d = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!rdata[fbit]) state_d = S_DONE;
        else if (free_q[slot_q] + FW'(1) >= FULLC) state_d = S_REMOVE;
        else state_d = S_SORT;
      end
      S_REMOVE: if (i_q + CW'(1) >= cnt_q) state_d = S_SORT;
      S_SORT: begin
        if (!sort_swap && i_q + CW'(1) >= cnt_q) state_d = S_DONE;
        else if (!sort_swap && cnt_q < CW'(2)) state_d = S_DONE;
      end
      S_DONE: if (!ov_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = row_base + AW'(w_q);
    wdata = '0;
    raddr = row_base + AW'(w_q);
    case (state_q)
      S_OPEN: begin
        // sweep the rows of the slot under test, not the last used one
        waddr = AW'(PW'(i_q) * PW'(WPB)) + AW'(w_q);
        we    = !(cnt_q >= CW'(NUM_BLOCK_SLOTS)) &&
                !(live_q[SW'(i_q)] && i_q < CW'(NUM_BLOCK_SLOTS));
      end
      S_SCANW: if (scan.found) begin
        we    = 1'b1;
        wdata = rdata | (64'd1 << bitpos);
      end
      S_FREE_RD: raddr = AW'(fslot_w * PW'(WPB)) + AW'(fword);
      S_FREE_CHK: begin
        we    = rdata[fbit];
        waddr = row_base + AW'(fword);
        wdata = rdata & ~(64'd1 << fbit);
      end
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      for (int s = 0; s < NUM_BLOCK_SLOTS; s++) begin
        free_q[s] <= FULLC;
        live_q[s] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      // load a new result beat, or drop the one just taken
      if (state_q == S_DONE && (!ov_q || !out_stall_i)) begin
        ov_q <= 1'b1;
      end else if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          hdl_q   <= handle_i;
          i_q     <= '0;
          w_q     <= '0;
          rel_q   <= 1'b0;
          res_s_q <= StOk;
          res_h_q <= '0;
        end
        S_FIND: begin
          if (i_q >= cnt_q) i_q <= '0;
          else if (free_q[order_q[SW'(i_q)]] != '0) begin
            slot_q <= order_q[SW'(i_q)];
            w_q    <= '0;
          end else i_q <= i_q + CW'(1);
        end
        S_OPEN: begin
          if (cnt_q >= CW'(NUM_BLOCK_SLOTS)) res_s_q <= StNoSlot;
          else if (live_q[SW'(i_q)] && i_q < CW'(NUM_BLOCK_SLOTS)) i_q <= i_q + CW'(1);
          else begin
            // sweep bitmap words clear, then register the block
            slot_q <= SW'(i_q);
            if (PW'(w_q) == PW'(WPB - 1)) begin
              live_q[SW'(i_q)]  <= 1'b1;
              free_q[SW'(i_q)]  <= FULLC;
              order_q[SW'(cnt_q)] <= SW'(i_q);
              cnt_q <= cnt_q + CW'(1);
              w_q   <= '0;
            end else w_q <= w_q + WIW'(1);
          end
        end
        S_SCANW: begin
          if (scan.found) begin
            free_q[slot_q] <= free_q[slot_q] - FW'(1);
            res_h_q <= HandleW'(PW'(slot_q) * PW'(BLOCK_CHUNKS)
                                + PW'(w_q) * 64 + PW'(bitpos));
            i_q  <= '0;
            j_q  <= '0;
          end else w_q <= w_q + WIW'(1);
        end
        S_FREE_RD: begin
          slot_q <= SW'(fslot_w);
          if (fslot_w >= PW'(NUM_BLOCK_SLOTS) || !live_q[SW'(fslot_w)]) begin
            res_s_q <= StNotAllc;
          end
        end
        S_FREE_CHK: begin
          i_q <= '0;
          j_q <= '0;
          if (!rdata[fbit]) res_s_q <= StNotAllc;
          else begin
            if (free_q[slot_q] < FULLC) free_q[slot_q] <= free_q[slot_q] + FW'(1);
            if (free_q[slot_q] + FW'(1) >= FULLC) begin
              live_q[slot_q] <= 1'b0;
              rel_q <= 1'b1;
            end
          end
        end
        S_REMOVE: begin
          // once the slot is found, shift the rest down one place per cycle
          if (i_q + CW'(1) < cnt_q && (j_q != '0 || order_q[SW'(i_q)] == slot_q)) begin
            order_q[SW'(i_q)] <= order_q[SW'(i_q + CW'(1))];
            j_q <= CW'(1);
          end
          if (i_q + CW'(1) >= cnt_q) begin
            cnt_q <= cnt_q - CW'(1);
            i_q   <= '0;
            j_q   <= '0;
          end else i_q <= i_q + CW'(1);
        end
        S_SORT: begin
          // insertion sort: i is the key index, j walks it down
          if (sort_swap) begin
            order_q[SW'(j_q - CW'(1))] <= ob;
            order_q[SW'(j_q)]          <= oa;
            j_q <= j_q - CW'(1);
          end else begin
            i_q <= i_q + CW'(1);
            j_q <= i_q + CW'(1);
          end
        end
        S_DONE: if (!ov_q || !out_stall_i) begin
          oh_q  <= res_h_q;
          os_q  <= res_s_q;
          orl_q <= rel_q;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o      = ov_q;
  assign chunk_handle_o   = oh_q;
  assign status_o         = os_q;
  assign block_released_o = orl_q;

  // A result never reports both a handle and an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (oh_q == '0 || os_q == StOk)) else $error("handle with error");
  // Released only on an ok free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && orl_q) |-> (os_q == StOk && oh_q == '0)) else $error("bad release");
  // Live count never exceeds the slot count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NUM_BLOCK_SLOTS)) else $error("live count overflow");
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: regression of the most-filled-first chunk allocator
// Drives allocate and free beats with random gaps, predicts each result with
// a local model of the block list and bitmaps, and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import mffca_pkg::*;

  localparam int unsigned Chunks = ChunksPerBlockDef;
  localparam int unsigned Slots  = NumBlockSlotsDef;
  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned FillBlocks = 2;

  typedef struct packed {
    logic [HandleW-1:0] chunk_handle;
    logic [StatusW-1:0] status;
    logic               block_released;
  } alloc_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               func_i = FuncAlloc;
  logic [HandleW-1:0] handle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [HandleW-1:0] chunk_handle_o;
  logic [StatusW-1:0] status_o;
  logic               block_released_o;

  most_filled_first_chunk_allocator_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .handle_i,
    .out_valid_o, .out_stall_i, .chunk_handle_o, .status_o, .block_released_o
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the allocator state.
  logic [Chunks-1:0] used_map [Slots];
  int unsigned       free_cnt [Slots];
  logic [Slots-1:0]  live_map;
  int unsigned       order_list [$];

  alloc_result_t  expected_q [$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  logic           stall_on = 1'b1;
  logic [HandleW-1:0] held_handles [$];

  function automatic void sort_by_free();
    int unsigned k, j, key;
    for (k = 1; k < order_list.size(); k++) begin
      key = order_list[k];
      j = k;
      while (j > 0 && free_cnt[order_list[j-1]] > free_cnt[key]) begin
        order_list[j] = order_list[j-1];
        j--;
      end
      order_list[j] = key;
    end
  endfunction

  function automatic alloc_result_t predict_alloc();
    alloc_result_t r;
    int slot;
    slot = -1;
    r = '0;
    foreach (order_list[k]) begin
      if (free_cnt[order_list[k]] > 0) begin
        slot = order_list[k];
        break;
      end
    end
    if (slot < 0) begin
      for (int s = 0; s < Slots; s++) begin
        if (!live_map[s]) begin
          slot = s;
          break;
        end
      end
      if (slot < 0) begin
        r.status = StNoSlot;
        return r;
      end
      live_map[slot] = 1'b1;
      free_cnt[slot] = Chunks;
      used_map[slot] = '0;
      order_list.insert(order_list.size(), slot);
    end
    for (int c = 0; c < Chunks; c++) begin
      if (!used_map[slot][c]) begin
        used_map[slot][c] = 1'b1;
        free_cnt[slot]--;
        r.chunk_handle = HandleW'(slot * Chunks + c);
        break;
      end
    end
    r.status = StOk;
    sort_by_free();
    return r;
  endfunction

  function automatic alloc_result_t predict_free(logic [HandleW-1:0] h);
    alloc_result_t r;
    int unsigned slot, c;
    r = '0;
    slot = h / Chunks;
    c = h % Chunks;
    if (slot >= Slots || !live_map[slot] || !used_map[slot][c]) begin
      r.status = StNotAllc;
      return r;
    end
    used_map[slot][c] = 1'b0;
    if (free_cnt[slot] < Chunks) free_cnt[slot]++;
    if (free_cnt[slot] == Chunks) begin
      foreach (order_list[k]) begin
        if (order_list[k] == slot) begin
          order_list.delete(k);
          break;
        end
      end
      live_map[slot] = 1'b0;
      r.block_released = 1'b1;
    end
    sort_by_free();
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    if ($urandom_range(9) < 7) return $urandom_range(2);
    return $urandom_range(40, 3);
  endfunction

  // Send one beat; predict its result at the accepting edge.
  task automatic send_op(logic f, logic [HandleW-1:0] h);
    alloc_result_t r;
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    handle_i   <= h;
    do @(posedge clk_i); while (in_stall_o);
    if (f == FuncAlloc) begin
      r = predict_alloc();
      if (r.status == StOk) held_handles.insert(held_handles.size(), r.chunk_handle);
    end else begin
      r = predict_free(h);
      foreach (held_handles[k]) begin
        if (r.status == StOk && held_handles[k] == h) begin
          held_handles.delete(k);
          break;
        end
      end
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic free_held(int unsigned pick);
    logic [HandleW-1:0] h;
    h = held_handles[pick];
    send_op(FuncFree, h);
  endtask

  // Receiver stall: random, with stretches of none.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if ($urandom_range(199) == 0) stall_on <= ~stall_on;
    out_stall_i <= stall_on && ($urandom_range(9) < 3 ||
                                ($urandom_range(49) == 0));
  end

  // Check each accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    alloc_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (chunk_handle_o !== e.chunk_handle) begin
          $error("chunk_handle expected %0d got %0d", e.chunk_handle, chunk_handle_o);
          errors++;
        end
        if (status_o !== e.status) begin
          $error("status expected %0d got %0d", e.status, status_o);
          errors++;
        end
        if (block_released_o !== e.block_released) begin
          $error("block_released expected %0d got %0d", e.block_released,
                 block_released_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CycleLimit) begin
      $display("most_filled_first_chunk_allocator_top regression: fail");
      $finish;
    end
  end

  // Directed: extremes of the handle, bad frees, block release.
  task automatic test_directed();
    send_op(FuncFree, '0);
    send_op(FuncFree, 11'h7FF);
    send_op(FuncAlloc, 11'h7FF);
    send_op(FuncAlloc, '0);
    send_op(FuncFree, 11'd1);
    send_op(FuncFree, 11'd1);
    send_op(FuncFree, 11'd200);
    send_op(FuncFree, 11'd0);
    send_op(FuncAlloc, 11'h555);
    send_op(FuncFree, 11'h2AA);
  endtask

  // Allocate two blocks' worth of chunks plus two, send four noise frees, then drain to empty.
  task automatic test_fill_drain();
    for (int k = 0; k < Chunks * FillBlocks + 2; k++) send_op(FuncAlloc, HandleW'($urandom));
    for (int k = 0; k < 4; k++) send_op(FuncFree, HandleW'($urandom));
    while (held_handles.size() > 0) free_held($urandom_range(held_handles.size() - 1));
  endtask

  // Random mix: about half allocates, otherwise mostly valid frees of held chunks, some noise frees.
  task automatic test_random(int unsigned n);
    int unsigned roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (roll < 50 || held_handles.size() == 0) send_op(FuncAlloc, HandleW'($urandom));
      else if (roll < 90) free_held($urandom_range(held_handles.size() - 1));
      else send_op(FuncFree, HandleW'($urandom));
    end
  endtask

  initial begin
    foreach (used_map[s]) begin
      used_map[s] = '0;
      free_cnt[s] = Chunks;
    end
    live_map = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    test_fill_drain();
    test_random(290);
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("most_filled_first_chunk_allocator_top regression: pass");
    end else begin
      $display("most_filled_first_chunk_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
